// ===== hw/rtl/fup_pkg.sv =====
// Package for the form body field parser: payload structs, record kinds,
// character constants and queue sizing shared by all modules.
// No dependencies.
package fup_pkg;

  // Default sizing, handed down from the top level.
  localparam int FIELD_COUNT_DEF = 4;
  localparam int KEY_CHARS_DEF   = 8;

  // Largest field buffer; a larger capacity setting acts as this.
  localparam int VALUE_MAX = 128;

  // Configuration register map.
  localparam int          CFG_IDX_W     = 4;
  localparam int          CFG_DATA_W    = 64;
  localparam int          CFG_CAP_BASE  = 4;
  localparam logic [7:0]  CAP_RESET     = 8'd16;
  localparam logic [7:0]  CAP_MIN       = 8'd2;

  // Special body characters.
  localparam logic [7:0] CH_PCT = 8'h25;
  localparam logic [7:0] CH_EQ  = 8'h3D;
  localparam logic [7:0] CH_AMP = 8'h26;

  // Records per body byte and queue depth in byte groups.
  localparam int MAX_RECS = 4;
  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  typedef enum logic [1:0] {
    REC_CHAR = 2'd0,
    REC_DONE = 2'd1,
    REC_SKIP = 2'd2,
    REC_END  = 2'd3
  } rec_kind_t;

  // One input transaction.
  typedef struct packed {
    logic [7:0] body_byte;
    logic       body_end;
  } fup_in_t;

  // One result transaction.
  typedef struct packed {
    rec_kind_t  record_kind;
    logic [1:0] field_index;
    logic [7:0] value_char;
    logic [6:0] char_position;
    logic [6:0] value_length;
    logic [3:0] parsed_mask;
    logic       run_last;
  } fup_out_t;

  // All records caused by one body byte.
  typedef struct packed {
    logic [2:0]               cnt;
    fup_out_t [MAX_RECS-1:0]  recs;
  } fup_group_t;

  // Write side of the queue.
  typedef struct packed {
    logic       push;
    fup_group_t group;
  } fup_push_t;

  // Read side of the queue.
  typedef struct packed {
    logic       empty;
    logic       full;
    fup_group_t head;
  } fup_qstat_t;

endpackage

// ===== hw/rtl/fup_front.sv =====
// Front end of the form body parser: configuration registers, token and key
// matching state, percent decoding, and assembly of each byte's record group.
// Depends on fup_pkg.
module fup_front import fup_pkg::*; #(
  parameter int FIELD_COUNT = FIELD_COUNT_DEF,
  parameter int KEY_CHARS   = KEY_CHARS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  fup_in_t               in_data,
  output logic                  in_stall,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  fup_qstat_t            qstat,
  output fup_push_t             qpush
);

  localparam int KEY_W = KEY_CHARS * 8;

  typedef enum logic [2:0] {
    PCT_NONE = 3'b001,
    PCT_ONE  = 3'b010,
    PCT_TWO  = 3'b100
  } pct_t;

  // Configuration registers.
  logic [KEY_W-1:0] key_r [FIELD_COUNT];
  logic [7:0]       cap_r [FIELD_COUNT];

  // Parse state.
  logic [3:0] fm_r, cand_r, kcc_r;
  logic [1:0] off_r, mf_r;
  logic       ivp_r, mv_r;
  logic [6:0] sc_r;
  pct_t       pp_r;
  logic [7:0] hd_r;

  // Next values.
  logic [3:0] fm_nxt, cand_nxt, kcc_nxt;
  logic [1:0] off_nxt, mf_nxt;
  logic       ivp_nxt, mv_nxt;
  logic [6:0] sc_nxt;
  pct_t       pp_nxt;
  logic [7:0] hd_nxt;

  fup_group_t grp;
  logic       accept;

  logic [7:0] b;
  logic       last, sep, key_eq, key_ch, do_fk, fk_hit, vb, tok_end;
  logic [1:0] fk_field;
  logic [7:0] kb_cur [FIELD_COUNT];
  logic [7:0] kb_fin [FIELD_COUNT];
  logic [7:0] cap_sel, cap_c, dec;
  logic [6:0] lim;

  assign in_stall = qstat.full;
  assign accept   = in_valid && !in_stall;
  assign b        = in_data.body_byte;
  assign last     = in_data.body_end;

  // Writes set key i at index i, capacity i at CFG_CAP_BASE + i; others are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < FIELD_COUNT; i++) begin
        key_r[i] <= '0;
        cap_r[i] <= CAP_RESET;
      end
    end else if (cfg_valid) begin
      for (int i = 0; i < FIELD_COUNT; i++) begin
        if (cfg_index == CFG_IDX_W'(i)) begin
          key_r[i] <= cfg_data[KEY_W-1:0];
        end
        if (cfg_index == CFG_IDX_W'(CFG_CAP_BASE + i)) begin
          cap_r[i] <= cfg_data[7:0];
        end
      end
    end
  end

  // Byte step: key compare, key finish, value decode, token and body end.
  always_comb begin
    fm_nxt   = fm_r;
    cand_nxt = cand_r;
    kcc_nxt  = kcc_r;
    off_nxt  = off_r;
    mf_nxt   = mf_r;
    ivp_nxt  = ivp_r;
    mv_nxt   = mv_r;
    sc_nxt   = sc_r;
    pp_nxt   = pp_r;
    hd_nxt   = hd_r;
    grp      = '0;
    fk_hit   = 1'b0;
    fk_field = '0;
    cap_sel  = CAP_RESET;
    dec      = {hd_r[3:0] + (hd_r[6] ? 4'd9 : 4'd0), b[3:0] + (b[6] ? 4'd9 : 4'd0)};

    sep     = (b == CH_AMP) && (off_r == 2'd2);
    key_eq  = !sep && !ivp_r && (b == CH_EQ) && (off_r != 2'd0);
    key_ch  = !sep && !ivp_r && !key_eq;
    vb      = !sep && ivp_r && mv_r;
    tok_end = sep || last;

    // Key character: drop candidates whose key differs at this position.
    for (int i = 0; i < FIELD_COUNT; i++) begin
      kb_cur[i] = '0;
      for (int j = 0; j < KEY_CHARS; j++) begin
        if (kcc_r == 4'(j)) begin
          kb_cur[i] = key_r[i][8*j +: 8];
        end
      end
    end
    if (key_ch) begin
      for (int i = 0; i < FIELD_COUNT; i++) begin
        if (kcc_r >= 4'(KEY_CHARS) || b == 8'd0 || kb_cur[i] != b) begin
          cand_nxt[i] = 1'b0;
        end
      end
      if (kcc_r != 4'hf) begin
        kcc_nxt = kcc_r + 4'd1;
      end
    end

    // Key finish: lowest unfilled candidate whose key ends here wins.
    for (int i = 0; i < FIELD_COUNT; i++) begin
      kb_fin[i] = '0;
      for (int j = 0; j < KEY_CHARS; j++) begin
        if (kcc_nxt == 4'(j)) begin
          kb_fin[i] = key_r[i][8*j +: 8];
        end
      end
    end
    for (int i = FIELD_COUNT - 1; i >= 0; i--) begin
      if (cand_nxt[i] && !fm_r[i] && kcc_nxt != 4'd0 && kcc_nxt <= 4'(KEY_CHARS) &&
          (kcc_nxt == 4'(KEY_CHARS) || kb_fin[i] == 8'd0)) begin
        fk_hit   = 1'b1;
        fk_field = 2'(i);
      end
    end
    do_fk = key_eq || (tok_end && !ivp_r);
    if (do_fk && fk_hit) begin
      mv_nxt           = 1'b1;
      mf_nxt           = fk_field;
      fm_nxt[fk_field] = 1'b1;
    end
    if (key_eq) begin
      ivp_nxt = 1'b1;
    end

    // Storage limit of the matched field.
    for (int i = 0; i < FIELD_COUNT; i++) begin
      if (mf_nxt == 2'(i)) begin
        cap_sel = cap_r[i];
      end
    end
    if (cap_sel < CAP_MIN) begin
      cap_c = CAP_MIN;
    end else if (cap_sel > 8'(VALUE_MAX)) begin
      cap_c = 8'(VALUE_MAX);
    end else begin
      cap_c = cap_sel;
    end
    lim = 7'(cap_c - 8'd1);

    // Value byte with percent decoding.
    if (vb) begin
      unique case (pp_r)
        PCT_NONE: begin
          if (b == CH_PCT) begin
            pp_nxt = PCT_ONE;
          end else if (sc_nxt < lim) begin
            grp.recs[grp.cnt[1:0]].record_kind   = REC_CHAR;
            grp.recs[grp.cnt[1:0]].field_index   = mf_nxt;
            grp.recs[grp.cnt[1:0]].value_char    = b;
            grp.recs[grp.cnt[1:0]].char_position = sc_nxt;
            grp.cnt = grp.cnt + 3'd1;
            sc_nxt  = sc_nxt + 7'd1;
          end
        end
        PCT_ONE: begin
          hd_nxt = b;
          pp_nxt = PCT_TWO;
        end
        PCT_TWO: begin
          pp_nxt = PCT_NONE;
          if (sc_nxt < lim) begin
            grp.recs[grp.cnt[1:0]].record_kind   = REC_CHAR;
            grp.recs[grp.cnt[1:0]].field_index   = mf_nxt;
            grp.recs[grp.cnt[1:0]].value_char    = dec;
            grp.recs[grp.cnt[1:0]].char_position = sc_nxt;
            grp.cnt = grp.cnt + 3'd1;
            sc_nxt  = sc_nxt + 7'd1;
          end
        end
        default: begin
          pp_nxt = PCT_NONE;
        end
      endcase
    end

    // Token offset counts to two and holds.
    if (!sep && off_r != 2'd2) begin
      off_nxt = off_r + 2'd1;
    end

    // Token end: flush a pending escape literally, then done or skip.
    if (tok_end) begin
      if (mv_nxt) begin
        if (pp_nxt != PCT_NONE && sc_nxt < lim) begin
          grp.recs[grp.cnt[1:0]].record_kind   = REC_CHAR;
          grp.recs[grp.cnt[1:0]].field_index   = mf_nxt;
          grp.recs[grp.cnt[1:0]].value_char    = CH_PCT;
          grp.recs[grp.cnt[1:0]].char_position = sc_nxt;
          grp.cnt = grp.cnt + 3'd1;
          sc_nxt  = sc_nxt + 7'd1;
        end
        if (pp_nxt == PCT_TWO && sc_nxt < lim) begin
          grp.recs[grp.cnt[1:0]].record_kind   = REC_CHAR;
          grp.recs[grp.cnt[1:0]].field_index   = mf_nxt;
          grp.recs[grp.cnt[1:0]].value_char    = hd_nxt;
          grp.recs[grp.cnt[1:0]].char_position = sc_nxt;
          grp.cnt = grp.cnt + 3'd1;
          sc_nxt  = sc_nxt + 7'd1;
        end
        grp.recs[grp.cnt[1:0]].record_kind  = REC_DONE;
        grp.recs[grp.cnt[1:0]].field_index  = mf_nxt;
        grp.recs[grp.cnt[1:0]].value_length = sc_nxt;
      end else begin
        grp.recs[grp.cnt[1:0]].record_kind = REC_SKIP;
      end
      grp.cnt  = grp.cnt + 3'd1;
      off_nxt  = '0;
      ivp_nxt  = 1'b0;
      cand_nxt = 4'hf;
      kcc_nxt  = '0;
      mv_nxt   = 1'b0;
      mf_nxt   = '0;
      sc_nxt   = '0;
      pp_nxt   = PCT_NONE;
      hd_nxt   = '0;
    end

    // Body end: report the parsed mask and start a new body.
    if (last) begin
      grp.recs[grp.cnt[1:0]].record_kind = REC_END;
      grp.recs[grp.cnt[1:0]].parsed_mask = fm_nxt;
      grp.cnt = grp.cnt + 3'd1;
      fm_nxt  = '0;
    end
  end

  assign qpush.push  = accept && (grp.cnt != 3'd0);
  assign qpush.group = grp;

  // Parse state registers advance on each accepted byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fm_r   <= '0;
      cand_r <= 4'hf;
      kcc_r  <= '0;
      off_r  <= '0;
      mf_r   <= '0;
      ivp_r  <= 1'b0;
      mv_r   <= 1'b0;
      sc_r   <= '0;
      pp_r   <= PCT_NONE;
      hd_r   <= '0;
    end else if (accept) begin
      fm_r   <= fm_nxt;
      cand_r <= cand_nxt;
      kcc_r  <= kcc_nxt;
      off_r  <= off_nxt;
      mf_r   <= mf_nxt;
      ivp_r  <= ivp_nxt;
      mv_r   <= mv_nxt;
      sc_r   <= sc_nxt;
      pp_r   <= pp_nxt;
      hd_r   <= hd_nxt;
    end
  end

endmodule

// ===== hw/rtl/fup_queue.sv =====
// Short queue of record groups between the parser front end and the
// result sequencer. Depends on fup_pkg.
module fup_queue import fup_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  fup_push_t  qpush,
  input  logic       pop,
  output fup_qstat_t qstat
);

  localparam int CNT_W = $clog2(QDEPTH + 1);

  fup_group_t         mem_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_r, rd_r, wr_nxt, rd_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign qstat.empty = (cnt_r == '0);
  assign qstat.full  = (cnt_r == CNT_W'(QDEPTH));
  assign qstat.head  = mem_r[rd_r];

  assign do_push = qpush.push && !qstat.full;
  assign do_pop  = pop && !qstat.empty;

  // Pointer wrap and occupancy.
  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_nxt = (rd_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_r + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Group storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= qpush.group;
    end
  end

endmodule

// ===== hw/rtl/fup_back.sv =====
// Result sequencer: walks the records of the queue head one per cycle while
// out_stall is low and marks the last record of each byte. Depends on fup_pkg.
module fup_back import fup_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  fup_qstat_t qstat,
  output logic       pop,
  output logic       out_valid,
  output fup_out_t   out_data,
  input  logic       out_stall
);

  logic [1:0] idx_r, idx_nxt;
  logic       last_rec, take;

  assign out_valid = !qstat.empty;
  assign last_rec  = ({1'b0, idx_r} + 3'd1) == qstat.head.cnt;
  assign take      = out_valid && !out_stall;
  assign pop       = take && last_rec;

  // Current record, with the end-of-byte flag added.
  always_comb begin
    out_data          = qstat.head.recs[idx_r];
    out_data.run_last = last_rec;
  end

  always_comb begin
    idx_nxt = idx_r;
    if (take) begin
      idx_nxt = last_rec ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule

// ===== hw/rtl/form_urlencoded_field_parser.sv =====
// Top level of the form body field parser: front end, group queue and
// result sequencer. Depends on fup_pkg, fup_front, fup_queue and fup_back.
//
// Usage: body bytes enter on the in_ channel, one transaction per byte, with
// body_end set on the final byte. Each byte yields zero to four result
// transactions on the out_ channel: decoded value characters of a matched
// field, a done record with the stored length, a skip record for a key that
// matches no unfilled field, and on the final byte an end record with the
// parsed field mask. The last result of a byte carries run_last.
// Keys and capacities are written on the cfg_ port while the block is idle;
// cfg_ready is always high.
// Each accepted byte's record group is registered in the queue, and results
// are offered from the queue head. The parser takes one byte per cycle while
// each byte gives at most one result and out_stall is low; the output moves
// one record per cycle unless stalled. A two-group queue decouples the sides.
// Reset clears the parse state, keys to zero and capacities to 16. When the
// receiver stalls, the current record holds and the queue fills; once it is
// full, in_stall rises until a group drains.
module form_urlencoded_field_parser import fup_pkg::*; #(
  parameter int FIELD_COUNT = FIELD_COUNT_DEF,
  parameter int KEY_CHARS   = KEY_CHARS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  fup_in_t               in_data,
  output logic                  in_stall,
  output logic                  out_valid,
  output fup_out_t              out_data,
  input  logic                  out_stall,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  fup_push_t  qpush;
  fup_qstat_t qstat;
  logic       pop;

  // Configuration writes complete at once.
  assign cfg_ready = 1'b1;

  fup_front #(
    .FIELD_COUNT (FIELD_COUNT),
    .KEY_CHARS   (KEY_CHARS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .qstat     (qstat),
    .qpush     (qpush)
  );

  fup_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .qpush (qpush),
    .pop   (pop),
    .qstat (qstat)
  );

  fup_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .qstat     (qstat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

endmodule
